// ===== rtl/mic_pkg.sv =====
// Package for the multichannel input qualifier: sizes, codes, register set and
// controller/datapath command and status types. No dependencies.
package mic_pkg;

  localparam int CHANNELS = 16;
  localparam int HISTORY  = 8;

  localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIST_W  = (HISTORY > 1) ? $clog2(HISTORY) : 1;
  localparam int FILL_W  = $clog2(HISTORY + 1);
  localparam int SUM_W   = 16 + $clog2(HISTORY);
  localparam int DCNT_W  = $clog2(SUM_W + 1);
  localparam int ADDR_W  = (CHANNELS * HISTORY > 1) ? $clog2(CHANNELS * HISTORY) : 1;
  localparam int IDX_W   = 8;

  localparam logic       OP_PULSE    = 1'b0;
  localparam logic       OP_POLL     = 1'b1;
  localparam logic       KIND_SWITCH = 1'b0;
  localparam logic       KIND_FREQ   = 1'b1;
  localparam logic [1:0] STAT_OK     = 2'd0;
  localparam logic [1:0] STAT_LOW    = 2'd1;
  localparam logic [1:0] STAT_HIGH   = 2'd2;

  localparam logic [IDX_W-1:0] REG_ENABLED   = 8'd0;
  localparam logic [IDX_W-1:0] REG_FREQUENCY = 8'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW    = 8'd2;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE  = 8'd3;
  localparam logic [IDX_W-1:0] REG_LOW       = 8'd4;
  localparam logic [IDX_W-1:0] REG_HIGH      = 8'd5;

  typedef struct packed {
    logic [15:0] enabled_channels;
    logic [15:0] frequency_channels;
    logic [15:0] window_ticks;
    logic [15:0] debounce_ticks;
    logic [15:0] low_limit;
    logic [15:0] high_limit;
  } cfg_t;

  typedef struct packed {
    logic pulse;
    logic poll_start;
    logic sw_step;
    logic fr_tick;
    logic hist_write;
    logic rd_step;
    logic div_start;
    logic fr_emit;
    logic next_ch;
  } cmd_t;

  typedef struct packed {
    logic en;
    logic fr;
    logic close;
    logic flip;
    logic last_ch;
    logic sum_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/mic_if.sv =====
// Handshake channel interfaces: input word, result word and register write.
// Depends on mic_pkg for widths.
interface mic_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] edge_mask;
  logic [15:0] pin_levels;
  modport source (output valid, opcode, edge_mask, pin_levels, input ready);
  modport sink   (input valid, opcode, edge_mask, pin_levels, output ready);
endinterface

interface mic_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  channel;
  logic        report_kind;
  logic        switch_level;
  logic [15:0] average_count;
  logic [1:0]  freq_status;
  logic        last;
  modport source (output valid, channel, report_kind, switch_level, average_count,
                  freq_status, last, input ready);
  modport sink   (input valid, channel, report_kind, switch_level, average_count,
                  freq_status, last, output ready);
endinterface

interface mic_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [mic_pkg::IDX_W-1:0] index;
  logic [15:0]               data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mic_ctrl.sv =====
// Controller: walks the channels of a poll and sequences window close,
// history sum, divide and report. Depends on mic_pkg.
module mic_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_opcode,
  output logic              in_ready,
  input  mic_pkg::status_t  st,
  output mic_pkg::cmd_t     cmd
);
  import mic_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_CHAN, S_READ, S_DIV, S_EMIT} state_t;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == OP_POLL) begin
            cmd.poll_start = 1'b1;
            state_next     = S_CHAN;
          end else begin
            cmd.pulse = 1'b1;
          end
        end
      end
      S_CHAN: begin
        if (!st.en) begin
          cmd.next_ch = 1'b1;
        end else if (st.fr) begin
          if (st.close) begin
            cmd.hist_write = 1'b1;
            state_next     = S_READ;
          end else begin
            cmd.fr_tick = 1'b1;
            cmd.next_ch = 1'b1;
          end
        end else if (!st.flip || st.out_free) begin
          cmd.sw_step = 1'b1;
          cmd.next_ch = 1'b1;
        end
        if (cmd.next_ch && st.last_ch) state_next = S_IDLE;
      end
      S_READ: begin
        if (st.sum_done) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV;
        end else begin
          cmd.rd_step = 1'b1;
        end
      end
      S_DIV: begin
        if (st.div_done) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.fr_emit = 1'b1;
          cmd.next_ch = 1'b1;
          state_next  = st.last_ch ? S_IDLE : S_CHAN;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== rtl/mic_dp.sv =====
// Datapath: per-channel counters, history memory, sum, serial divider and
// result register. Depends on mic_pkg.
module mic_dp (
  input  logic              clk,
  input  logic              rst,
  input  mic_pkg::cfg_t     cfg,
  input  logic [15:0]       edge_mask,
  input  logic [15:0]       pin_levels,
  input  mic_pkg::cmd_t     cmd,
  output mic_pkg::status_t  st,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [3:0]        out_channel,
  output logic              out_kind,
  output logic              out_level,
  output logic [15:0]       out_average,
  output logic [1:0]        out_status,
  output logic              out_last
);
  import mic_pkg::*;

  logic              deb   [CHANNELS];
  logic [15:0]       tick  [CHANNELS];
  logic [15:0]       pulse [CHANNELS];
  logic [FILL_W-1:0] fill  [CHANNELS];
  logic [HIST_W-1:0] head  [CHANNELS];
  logic [15:0]       hist_mem [CHANNELS*HISTORY];

  logic [CH_W-1:0]     ch;
  logic [CHANNELS-1:0] pins, rep_mask, mask_next;
  logic [FILL_W-1:0]   rd_idx;
  logic                rd_valid;
  logic [15:0]         rd_data;
  logic [SUM_W-1:0]    acc;
  logic [SUM_W-1:0]    quo;
  logic [FILL_W:0]     rem;
  logic [DCNT_W-1:0]   dcnt;
  logic                div_busy;

  logic [15:0]       tick_inc;
  logic              lvl, close_c, flip_c, full_c;
  logic [HIST_W-1:0] wr_idx;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [FILL_W:0]   rem_sh;
  logic [15:0]       avg;
  logic [CHANNELS-1:0] above;

  assign tick_inc = (tick[ch] == 16'hFFFF) ? tick[ch] : tick[ch] + 16'd1;
  assign lvl      = pins[ch];
  assign close_c  = tick_inc >= cfg.window_ticks;
  assign flip_c   = (lvl != deb[ch]) && (tick_inc >= cfg.debounce_ticks);
  assign full_c   = (fill[ch] == FILL_W'(HISTORY));
  assign wr_idx   = full_c ? head[ch] : HIST_W'(fill[ch]);
  assign wr_addr  = ADDR_W'(ch) * ADDR_W'(HISTORY) + ADDR_W'(wr_idx);
  assign rd_addr  = ADDR_W'(ch) * ADDR_W'(HISTORY) + ADDR_W'(rd_idx);
  assign rem_sh   = {rem[FILL_W-1:0], quo[SUM_W-1]};
  assign avg      = quo[15:0];
  assign above    = (rep_mask >> ch) >> 1;

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      logic [15:0] ti;
      ti = (tick[i] == 16'hFFFF) ? tick[i] : tick[i] + 16'd1;
      mask_next[i] = cfg.enabled_channels[i] &&
                     (cfg.frequency_channels[i] ? (ti >= cfg.window_ticks)
                      : ((pin_levels[i] != deb[i]) && (ti >= cfg.debounce_ticks)));
    end
  end

  always_comb begin
    st.en       = cfg.enabled_channels[ch];
    st.fr       = cfg.frequency_channels[ch];
    st.close    = close_c;
    st.flip     = flip_c;
    st.last_ch  = (ch == CH_W'(CHANNELS - 1));
    st.sum_done = (rd_idx == fill[ch]) && !rd_valid;
    st.div_done = div_busy && (dcnt == '0);
    st.out_free = !out_valid || out_ready;
  end

  // per-channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        deb[i]   <= 1'b1;
        tick[i]  <= '0;
        pulse[i] <= '0;
        fill[i]  <= '0;
        head[i]  <= '0;
      end
    end else begin
      if (cmd.pulse) begin
        for (int i = 0; i < CHANNELS; i++)
          if (cfg.enabled_channels[i] && cfg.frequency_channels[i] && edge_mask[i] &&
              pulse[i] != 16'hFFFF)
            pulse[i] <= pulse[i] + 16'd1;
      end
      if (cmd.fr_tick) tick[ch] <= tick_inc;
      if (cmd.sw_step) begin
        if (lvl == deb[ch]) begin
          tick[ch] <= '0;
        end else if (flip_c) begin
          tick[ch] <= '0;
          deb[ch]  <= ~deb[ch];
        end else begin
          tick[ch] <= tick_inc;
        end
      end
      if (cmd.hist_write) begin
        tick[ch]  <= '0;
        pulse[ch] <= '0;
        if (full_c) head[ch] <= (head[ch] == HIST_W'(HISTORY - 1)) ? '0 : head[ch] + 1'b1;
        else        fill[ch] <= fill[ch] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_write) hist_mem[wr_addr] <= pulse[ch];
    rd_data <= hist_mem[rd_addr];
  end

  // walk, sum and divide
  always_ff @(posedge clk) begin
    if (rst) begin
      ch       <= '0;
      rd_valid <= 1'b0;
      div_busy <= 1'b0;
    end else begin
      if (cmd.poll_start) ch <= '0;
      else if (cmd.next_ch) ch <= ch + 1'b1;
      if (cmd.hist_write) begin
        rd_idx   <= '0;
        rd_valid <= 1'b0;
        acc      <= '0;
      end
      if (cmd.rd_step) begin
        rd_valid <= (rd_idx != fill[ch]);
        if (rd_idx != fill[ch]) rd_idx <= rd_idx + 1'b1;
        if (rd_valid) acc <= acc + SUM_W'(rd_data);
      end
      if (cmd.div_start) begin
        quo      <= acc;
        rem      <= '0;
        dcnt     <= DCNT_W'(SUM_W);
        div_busy <= 1'b1;
      end else if (div_busy && dcnt != '0) begin
        dcnt <= dcnt - 1'b1;
        if (rem_sh >= (FILL_W+1)'(fill[ch])) begin
          rem <= rem_sh - (FILL_W+1)'(fill[ch]);
          quo <= {quo[SUM_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[SUM_W-2:0], 1'b0};
        end
      end else if (cmd.fr_emit) begin
        div_busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.poll_start) begin
      pins     <= pin_levels[CHANNELS-1:0];
      rep_mask <= mask_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (cmd.sw_step && flip_c) begin
        out_valid    <= 1'b1;
        out_channel  <= 4'(ch);
        out_kind     <= KIND_SWITCH;
        out_level    <= ~deb[ch];
        out_average  <= '0;
        out_status   <= STAT_OK;
        out_last     <= (above == '0);
      end
      if (cmd.fr_emit) begin
        out_valid    <= 1'b1;
        out_channel  <= 4'(ch);
        out_kind     <= KIND_FREQ;
        out_level    <= 1'b0;
        out_average  <= avg;
        if (avg < cfg.low_limit)       out_status <= STAT_LOW;
        else if (avg > cfg.high_limit) out_status <= STAT_HIGH;
        else                           out_status <= STAT_OK;
        out_last     <= (above == '0);
      end
    end
  end
endmodule

// ===== rtl/multichannel_input_qualifier_top.sv =====
// Top level of the multichannel input qualifier: register bank, controller
// and datapath. Depends on mic_pkg, mic_if, mic_ctrl and mic_dp.
//
//  port    dir   word
//  in_ch   sink  opcode, edge_mask, pin_levels
//  out_ch  src   channel, report_kind, switch_level, average_count, freq_status, last
//  cfg     sink  index, data (always ready)
//
// A pulse word is accepted while idle. A poll walks every channel in turn; a
// closing window adds history reads, a serial divide and the report.
// Reset is synchronous; no clearing pass. A full result register stalls the walk.
module multichannel_input_qualifier_top (
  input logic       clk,
  input logic       rst,
  mic_in_if.sink    in_ch,
  mic_out_if.source out_ch,
  mic_cfg_if.sink   cfg
);
  import mic_pkg::*;

  cfg_t    regs;
  cmd_t    cmd;
  status_t st;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.enabled_channels   <= 16'd0;
      regs.frequency_channels <= 16'd0;
      regs.window_ticks       <= 16'd100;
      regs.debounce_ticks     <= 16'd5;
      regs.low_limit          <= 16'd0;
      regs.high_limit         <= 16'hFFFF;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_ENABLED:   regs.enabled_channels   <= cfg.data;
        REG_FREQUENCY: regs.frequency_channels <= cfg.data;
        REG_WINDOW:    regs.window_ticks       <= cfg.data;
        REG_DEBOUNCE:  regs.debounce_ticks     <= cfg.data;
        REG_LOW:       regs.low_limit          <= cfg.data;
        REG_HIGH:      regs.high_limit         <= cfg.data;
        default: ;
      endcase
    end
  end

  mic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  mic_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg         (regs),
    .edge_mask   (in_ch.edge_mask),
    .pin_levels  (in_ch.pin_levels),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (out_ch.ready),
    .out_valid   (out_ch.valid),
    .out_channel (out_ch.channel),
    .out_kind    (out_ch.report_kind),
    .out_level   (out_ch.switch_level),
    .out_average (out_ch.average_count),
    .out_status  (out_ch.freq_status),
    .out_last    (out_ch.last)
  );
endmodule
